@@ rtl/livar_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the linearized imputation variance block.
// Used by livar_div and linearized_imputation_variance_top.
package livar_pkg;

    localparam int VAL_W  = 32;
    localparam int CAT_W  = 5;
    localparam int VAR_W  = 63;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_OBS      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FEW_ROWS      = 2'd2;
    localparam logic [STAT_W-1:0] ST_FILL_MISMATCH = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] imputed;
        logic [CAT_W-1:0]        filled;
        logic                    observed;
        logic signed [VAL_W-1:0] value;
    } t_row;

endpackage

@@ rtl/livar_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on livar_pkg only through the project import convention.
module livar_div
    import livar_pkg::*;
#(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_q[NUM_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/linearized_imputation_variance_top.sv @@
`timescale 1ns / 1ps
// Linearized variance of one imputed column: row memory, category accumulators, sequencer.
// Depends on livar_pkg and livar_div.
//
//  channel | ports                          | beat
//  s       | i_s_tvalid/o_s_tready/tdata/tlast | one row; tlast marks the final row
//  m       | o_m_tvalid/i_m_tready/o_m_tdata   | one result per column
//  cfg     | i_cfg_valid/o_cfg_ready/i_cfg_data| num_categories
//
// Rows load into the row memory one per cycle while o_s_tready is high. After the
// final row the sequencer sums the filled counts of the k categories and checks the
// column, then per row takes a missing row's imputed value or computes an observed
// row's eta with the eta divider, and last forms the result with the variance divider.
// Reset is synchronous; no clearing pass is needed.
// A result waiting in the output register holds the next column only at its end.
module linearized_imputation_variance_top
    import livar_pkg::*;
#(
    parameter int MAX_ROWS       = 1024,
    parameter int MAX_CATEGORIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // y_value, y_observed, cell_category, filled_category, imputed_value
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // variance, status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int AW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_ROWS + 1);
    localparam int CIW  = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int KW   = CIW + 1;
    localparam int SW   = VAL_W + CW;
    localparam int NW   = 2 * CW + 34;
    localparam int EQW  = NW + 1;
    localparam int EDW  = 2 * CW + 1;
    localparam int TW   = 33 + CW;
    localparam int SQW  = 63 + CW;
    localparam int FNW  = 66 + 2 * CW;
    localparam int FDW  = 3 * CW;
    localparam int MCW  = $clog2(TW + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SUMF, S_CHK, S_RD, S_CAT, S_MUL, S_SUM, S_DIV,
        S_ACC, S_SQ, S_FMN, S_FMT, S_FSUB, S_FDIV, S_DONE
    } t_state;

    t_state r_state;

    t_row                    w_in;
    logic                    w_beat;
    logic [KW-1:0]           w_k;
    logic [CAT_W-1:0]        r_ncat;

    t_row                    r_mem [MAX_ROWS];
    t_row                    r_rd;

    logic signed [SW-1:0]    r_csum [MAX_CATEGORIES];
    logic [CW-1:0]           r_cobs [MAX_CATEGORIES];
    logic [CW-1:0]           r_cfil [MAX_CATEGORIES];
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_idx;
    logic [KW-1:0]           r_g;
    logic [CW-1:0]           r_fsum;

    logic [CAT_W-1:0]        w_cell_m1;
    logic [CAT_W-1:0]        w_fill_m1;
    logic [CAT_W-1:0]        w_rfill_m1;
    logic [CIW-1:0]          w_cix;
    logic [CIW-1:0]          w_fix;
    logic [CIW-1:0]          w_rix;
    logic                    w_cell_ok;
    logic                    w_fill_ok;
    logic                    w_rfill_ok;

    logic [2*CW-1:0]         r_gr;
    logic [2*CW-1:0]         r_rr;
    logic signed [SW-1:0]    r_s;
    logic signed [CW:0]      r_diff;
    logic signed [VAL_W-1:0] r_y;
    logic signed [2*CW+32:0] r_pa;
    logic signed [SW+CW:0]   r_pb;
    logic signed [NW-1:0]    w_nsum;
    logic [NW-1:0]           w_mag;
    logic                    r_neg;
    logic signed [VAL_W-1:0] r_eta;
    logic [63:0]             r_sq;
    logic signed [TW-1:0]    r_tot;
    logic [SQW-1:0]          r_sumsq;
    logic [TW-1:0]           w_tabs;

    logic                    w_estart;
    logic [EQW-1:0]          w_enum;
    logic [EDW-1:0]          w_eden;
    logic                    w_edone;
    logic [EQW-1:0]          w_equot;

    logic [FNW-1:0]          r_ma;
    logic [TW-1:0]           r_mb;
    logic [FNW-1:0]          r_acc;
    logic [FNW-1:0]          w_acc_n;
    logic [FNW-1:0]          r_pn;
    logic [MCW-1:0]          r_cnt;
    logic [2*CW-1:0]         r_nn;
    logic [FDW-1:0]          r_den;
    logic                    w_fstart;
    logic                    w_fdone;
    logic [FNW-1:0]          w_fquot;

    logic                    r_ovalid;
    logic [VAR_W-1:0]        r_var;
    logic [STAT_W-1:0]       r_stat;
    logic [VAR_W-1:0]        r_res_var;
    logic [STAT_W-1:0]       r_res_stat;

    assign w_in.value    = i_s_tdata[31:0];
    assign w_in.observed = i_s_tdata[32];
    assign w_in.filled   = i_s_tdata[42:38];
    assign w_in.imputed  = i_s_tdata[74:43];

    assign o_s_tready  = (r_state == S_LOAD);
    assign w_beat      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_ncat == '0) begin
            w_k = KW'(1);
        end else if (32'(r_ncat) > MAX_CATEGORIES) begin
            w_k = KW'(MAX_CATEGORIES);
        end else begin
            w_k = KW'(r_ncat);
        end
    end

    assign w_cell_m1  = i_s_tdata[37:33] - 1'b1;
    assign w_fill_m1  = i_s_tdata[42:38] - 1'b1;
    assign w_rfill_m1 = r_rd.filled - 1'b1;
    assign w_cix      = CIW'(w_cell_m1);
    assign w_fix      = CIW'(w_fill_m1);
    assign w_rix      = CIW'(w_rfill_m1);
    assign w_cell_ok  = (i_s_tdata[37:33] != '0) && (32'(i_s_tdata[37:33]) <= MAX_CATEGORIES);
    assign w_fill_ok  = (i_s_tdata[42:38] != '0) && (32'(i_s_tdata[42:38]) <= MAX_CATEGORIES);
    assign w_rfill_ok = (r_rd.filled != '0) && (9'(r_rd.filled) <= 9'(w_k));

    assign w_nsum   = NW'(r_pa) + NW'(r_pb);
    assign w_mag    = w_nsum[NW-1] ? NW'(-w_nsum) : NW'(w_nsum);
    assign w_estart = (r_state == S_SUM);
    assign w_enum   = {w_mag, 1'b0} + EQW'(r_rr);
    assign w_eden   = {r_rr, 1'b0};

    assign w_tabs   = r_tot[TW-1] ? TW'(-r_tot) : TW'(r_tot);
    assign w_acc_n  = r_mb[0] ? (r_acc + r_ma) : r_acc;
    assign w_fstart = (r_state == S_FSUB);

    livar_div #(.NUM_W(EQW), .DEN_W(EDW)) u_eta_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_estart),
        .i_num   (w_enum),
        .i_den   (w_eden),
        .o_done  (w_edone),
        .o_quot  (w_equot)
    );

    livar_div #(.NUM_W(FNW), .DEN_W(FDW)) u_var_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fstart),
        .i_num   (r_pn - r_acc),
        .i_den   (r_den),
        .o_done  (w_fdone),
        .o_quot  (w_fquot)
    );

    always_ff @(posedge i_clk) begin
        if (w_beat && (r_n < CW'(MAX_ROWS))) begin
            r_mem[r_n[AW-1:0]] <= w_in;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncat <= CAT_W'(1);
        end else if (i_cfg_valid) begin
            r_ncat <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < MAX_CATEGORIES; c++) begin
                r_csum[c] <= '0;
                r_cobs[c] <= '0;
                r_cfil[c] <= '0;
            end
        end else begin
            if (r_ovalid && i_m_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_beat) begin
                        if (r_n < CW'(MAX_ROWS)) begin
                            if (w_cell_ok) begin
                                r_csum[w_cix] <= r_csum[w_cix] + SW'(w_in.value);
                                r_cobs[w_cix] <= r_cobs[w_cix] + 1'b1;
                            end
                            if (w_fill_ok) begin
                                r_cfil[w_fix] <= r_cfil[w_fix] + 1'b1;
                            end
                            r_n <= r_n + 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_g     <= '0;
                            r_fsum  <= '0;
                            r_state <= S_SUMF;
                        end
                    end
                end
                S_SUMF: begin
                    r_fsum <= r_fsum + r_cfil[r_g[CIW-1:0]];
                    r_g    <= r_g + 1'b1;
                    if (r_g + 1'b1 == w_k) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_idx   <= '0;
                    r_tot   <= '0;
                    r_sumsq <= '0;
                    r_res_var <= '0;
                    if (r_n < CW'(2)) begin
                        r_res_stat <= ST_FEW_ROWS;
                        r_state    <= S_DONE;
                    end else if (r_fsum != r_n) begin
                        r_res_stat <= ST_FILL_MISMATCH;
                        r_state    <= S_DONE;
                    end else begin
                        r_res_stat <= ST_OK;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CAT;
                end
                S_CAT: begin
                    if (!r_rd.observed) begin
                        r_eta   <= r_rd.imputed;
                        r_state <= S_ACC;
                    end else if (!w_rfill_ok || (r_cobs[w_rix] == '0)) begin
                        r_res_stat <= ST_ZERO_OBS;
                        r_state    <= S_DONE;
                    end else begin
                        r_gr    <= r_cfil[w_rix] * r_cobs[w_rix];
                        r_rr    <= r_cobs[w_rix] * r_cobs[w_rix];
                        r_s     <= r_csum[w_rix];
                        r_diff  <= $signed({1'b0, r_cobs[w_rix]}) - $signed({1'b0, r_cfil[w_rix]});
                        r_y     <= r_rd.value;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pa    <= $signed({1'b0, r_gr}) * r_y;
                    r_pb    <= r_s * r_diff;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_neg   <= w_nsum[NW-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_edone) begin
                        if (!r_neg) begin
                            r_eta <= (w_equot > EQW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                     : $signed(w_equot[31:0]);
                        end else begin
                            r_eta <= (w_equot > EQW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                                       : -$signed(w_equot[31:0]);
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_tot   <= r_tot + TW'(r_eta);
                    r_sq    <= r_eta * r_eta;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sumsq <= r_sumsq + SQW'(r_sq);
                    r_idx   <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_n) begin
                        r_acc   <= '0;
                        r_ma    <= FNW'(r_sumsq + SQW'(r_sq));
                        r_mb    <= TW'(r_n);
                        r_cnt   <= MCW'(CW);
                        r_nn    <= r_n * r_n;
                        r_state <= S_FMN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_FMN: begin
                    if (r_cnt == MCW'(1)) begin
                        r_pn    <= w_acc_n;
                        r_acc   <= '0;
                        r_ma    <= FNW'(w_tabs);
                        r_mb    <= w_tabs;
                        r_cnt   <= MCW'(TW);
                        r_state <= S_FMT;
                    end else begin
                        r_ma  <= {r_ma[FNW-2:0], 1'b0};
                        r_mb  <= r_mb >> 1;
                        r_acc <= w_acc_n;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FMT: begin
                    r_den <= FDW'(r_nn * (r_n - 1'b1));
                    r_ma  <= {r_ma[FNW-2:0], 1'b0};
                    r_mb  <= r_mb >> 1;
                    r_acc <= w_acc_n;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == MCW'(1)) begin
                        r_state <= S_FSUB;
                    end
                end
                S_FSUB: begin
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    if (w_fdone) begin
                        r_res_var <= (w_fquot > FNW'(64'h7FFF_FFFF_FFFF_FFFF)) ? '1
                                                                              : w_fquot[VAR_W-1:0];
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_var    <= (r_res_stat == ST_OK) ? r_res_var : '0;
                        r_stat   <= r_res_stat;
                        r_n      <= '0;
                        for (int c = 0; c < MAX_CATEGORIES; c++) begin
                            r_csum[c] <= '0;
                            r_cobs[c] <= '0;
                            r_cfil[c] <= '0;
                        end
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_stat, r_var};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for linearized_imputation_variance_top: drives columns of rows
// with random idling and checks each column's variance and status against a predictor.
// Depends on livar_pkg and the block's RTL only.
module testbench
    import livar_pkg::*;
();

    localparam int ROW_DEPTH = 1024;
    localparam int CAT_DEPTH = 16;
    localparam int STALL_LIMIT = 400000;

    class livar_scoreboard;
        logic signed [31:0] row_value [ROW_DEPTH];
        bit                 row_obs   [ROW_DEPTH];
        logic [4:0]         row_fill  [ROW_DEPTH];
        logic signed [31:0] row_imp   [ROW_DEPTH];
        longint             cat_sum   [CAT_DEPTH];
        int                 cat_obs   [CAT_DEPTH];
        int                 cat_fill  [CAT_DEPTH];
        int                 rows;
        int                 num_cat;
        logic [62:0]        exp_var [$];
        logic [1:0]         exp_stat [$];
        int                 errors;

        function new();
            clear_column();
            num_cat = 1;
            errors = 0;
        endfunction

        function void clear_column();
            for (int c = 0; c < CAT_DEPTH; c++) begin
                cat_sum[c] = 0;
                cat_obs[c] = 0;
                cat_fill[c] = 0;
            end
            rows = 0;
        endfunction

        // Eta of an observed row, rounded half away from zero, saturated to 32 bits.
        function longint adjusted_value(longint y, longint s, longint r, longint g);
            logic signed [127:0] num, mag, d, q;
            num = g * r * y + s * (r - g);
            mag = (num < 0) ? -num : num;
            d = r * r;
            q = (2 * mag + d) / (2 * d);
            if (num >= 0)
                return (q > 128'sd2147483647) ? 64'sd2147483647 : longint'(q);
            return (q > 128'sd2147483648) ? -64'sd2147483648 : -longint'(q);
        endfunction

        function void note_row(logic [79:0] data, logic last);
            logic signed [31:0] y, imp;
            logic [4:0] cat_raw, fill;
            int k, fsum, n, c;
            logic [1:0] st;
            longint eta [ROW_DEPTH];
            longint total, mean, rem, dv;
            logic [127:0] acc, scaled, q;
            y = data[31:0];
            cat_raw = data[37:33];
            fill = data[42:38];
            imp = data[74:43];
            if (rows < ROW_DEPTH) begin
                row_value[rows] = y;
                row_obs[rows] = data[32];
                row_fill[rows] = fill;
                row_imp[rows] = imp;
                if (cat_raw >= 1 && cat_raw <= CAT_DEPTH) begin
                    cat_sum[cat_raw-1] += y;
                    cat_obs[cat_raw-1]++;
                end
                if (fill >= 1 && fill <= CAT_DEPTH) cat_fill[fill-1]++;
                rows++;
            end
            if (!last) return;
            n = rows;
            k = (num_cat < 1) ? 1 : (num_cat > CAT_DEPTH) ? CAT_DEPTH : num_cat;
            fsum = 0;
            for (int g = 0; g < k; g++) fsum += cat_fill[g];
            st = ST_OK;
            if (n < 2) st = ST_FEW_ROWS;
            else if (fsum != n) st = ST_FILL_MISMATCH;
            else begin
                for (int i = 0; i < n && st == ST_OK; i++) begin
                    if (row_obs[i]) begin
                        c = int'(row_fill[i]) - 1;
                        if (c < 0 || c >= k || cat_obs[c] == 0) st = ST_ZERO_OBS;
                        else eta[i] = adjusted_value(row_value[i], cat_sum[c], cat_obs[c],
                                                     cat_fill[c]);
                    end else begin
                        eta[i] = row_imp[i];
                    end
                end
            end
            q = 0;
            if (st == ST_OK) begin
                total = 0;
                for (int i = 0; i < n; i++) total += eta[i];
                mean = total / n;
                if (total % n != 0 && total < 0) mean--;
                rem = total - mean * n;
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    dv = eta[i] - mean;
                    if (dv < 0) dv = -dv;
                    acc += 128'(dv) * 128'(dv);
                end
                scaled = acc * 128'(n) - 128'(rem) * 128'(rem);
                q = scaled / (128'(n) * 128'(n) * 128'(n - 1));
                if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
            end
            exp_var = {exp_var, q[62:0]};
            exp_stat = {exp_stat, st};
            clear_column();
        endfunction

        function void check_result(logic [71:0] data);
            logic [62:0] ev;
            logic [1:0] es;
            if (exp_var.size() == 0) begin
                $display("%0t: unexpected result variance=%0h status=%0d", $time,
                         data[62:0], data[64:63]);
                errors++;
                return;
            end
            ev = exp_var.pop_front();
            es = exp_stat.pop_front();
            if (data[62:0] !== ev) begin
                $display("%0t: variance expected %0h actual %0h", $time, ev, data[62:0]);
                errors++;
            end
            if (data[64:63] !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, data[64:63]);
                errors++;
            end
        endfunction

        function int pending();
            return exp_var.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;  // y_value, y_observed, cell_category, filled_category, imputed_value
    logic        i_s_tlast = 0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [71:0] o_m_tdata;       // variance, status
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    livar_scoreboard sb = new();
    int  rows_sent = 0;
    bit  quiet = 0;
    int  sink_hold = 0;
    int  idle_cycles = 0;

    linearized_imputation_variance_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_row(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.num_cat = i_cfg_data;
        end
    end

    // Sink stalls in random bursts, started only while quiet is clear.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_tready <= 0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 4);
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_row(logic signed [31:0] y, bit obs, logic [4:0] cat_raw,
                            logic [4:0] fill, logic signed [31:0] imp, bit last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {5'b0, imp, fill, cat_raw, obs, y};
        i_s_tlast <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rows_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_categories(logic [4:0] value);
        wait_drained();
        i_cfg_valid <= 1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    // Random column; in broken ones some rows use arbitrary categories.
    task automatic send_column(int len, bit broken);
        int k;
        logic [4:0] cat_raw, fill;
        k = (sb.num_cat < 1) ? 1 : (sb.num_cat > CAT_DEPTH) ? CAT_DEPTH : sb.num_cat;
        for (int i = 0; i < len; i++) begin
            fill = $urandom_range(1, k);
            cat_raw = fill;
            if (broken && $urandom_range(0, 2) == 0) begin
                cat_raw = $urandom_range(0, 31);
                fill = $urandom_range(0, 31);
            end
            send_row(pick_value(), $urandom_range(0, 1), cat_raw, fill, pick_value(),
                     i == len - 1);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_row(32'sd100, 1, 5'd1, 5'd1, 32'sd0, 1);
        send_row(32'h7FFF_FFFF, 1, 5'd1, 5'd1, 32'h8000_0000, 0);
        send_row(32'h8000_0000, 1, 5'd1, 5'd1, 32'h7FFF_FFFF, 1);
        send_row(32'h8000_0000, 0, 5'd1, 5'd1, 32'h8000_0000, 0);
        send_row(32'h7FFF_FFFF, 0, 5'd1, 5'd1, 32'h7FFF_FFFF, 1);
        write_categories(5'd2);
        send_row(32'sd65536, 1, 5'd2, 5'd1, 32'sd0, 0);
        send_row(32'sd131072, 0, 5'd2, 5'd2, 32'sd0, 1);
        send_row(32'sd65536, 1, 5'd1, 5'd3, 32'sd0, 0);
        send_row(32'sd65536, 1, 5'd1, 5'd1, 32'sd0, 1);
        write_categories(5'd0);
        send_row(-32'sd65536, 1, 5'd1, 5'd1, 32'sd0, 0);
        send_row(32'sd196608, 1, 5'd1, 5'd1, 32'sd0, 0);
        send_row(32'sd5, 0, 5'd0, 5'd1, 32'sd12345, 1);
        write_categories(5'd31);
        send_row(32'sd1000, 1, 5'd16, 5'd16, 32'sd0, 0);
        send_row(32'sd3000, 1, 5'd16, 5'd16, 32'sd0, 0);
        send_row(32'sd7, 1, 5'd17, 5'd16, 32'sd0, 1);
        send_row(32'sd7, 1, 5'd16, 5'd17, 32'sd0, 0);
        send_row(32'sd9, 1, 5'd16, 5'd0, 32'sd0, 1);

        write_categories(5'd16);
        send_column(1026, 0);

        while (rows_sent < 1150) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_categories(5'd1);
                    1: write_categories(5'd16);
                    default: write_categories($urandom_range(0, 31));
                endcase
            end
            if (rows_sent > 1080) quiet = 1;
            send_column(($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(1, 12),
                        $urandom_range(0, 6) == 0);
        end
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ linearized_imputation_variance_top.f @@
rtl/livar_pkg.sv
rtl/livar_div.sv
rtl/linearized_imputation_variance_top.sv
verif/testbench.sv
